/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/viq_pkg.sv */
// Types and constants for the virtual IRQ latch and pending queue block.
`timescale 1ns / 1ps
`default_nettype none

package viq_pkg;

  localparam int unsigned GUEST_COUNT    = 2;
  localparam int unsigned GUEST_W        = 1;
  localparam int unsigned QUEUE_SLOTS_DEF = 64;
  localparam int unsigned ID_W           = 10;
  localparam int unsigned ACTION_W       = 4;
  localparam int unsigned STATUS_W       = 2;

  localparam logic [ID_W-1:0] SPURIOUS_ID = 10'h3FF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_EOI_FWD      = 4'd0,
    ACT_INJECT_CUR   = 4'd1,
    ACT_READ_LATCH   = 4'd2,
    ACT_PUSH_OWN     = 4'd3,
    ACT_POP_ADAPT    = 4'd4,
    ACT_QUERY        = 4'd5,
    ACT_PUSH_OTHER   = 4'd6,
    ACT_POP          = 4'd7,
    ACT_INJECT_OTHER = 4'd8,
    ACT_GUEST_EOI    = 4'd9
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_SWALLOWED = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic load_rd;  // capture queue read data into the result
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pop_read; // offered item pops a non-empty queue
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/viq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module viq_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hdl/viq_ctrl.sv */
// Controller state machine: input transfer, queue read wait, result hold.
`timescale 1ns / 1ps
`default_nettype none

module viq_ctrl import viq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.load_rd  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.pop_read ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        cmd_o.load_rd = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

`include "assert_macros.svh"

  `ASSERT_NEXT(a_pop_waits_read, clk_i, rst_ni, cmd_o.accept && status_i.pop_read, state_q == ST_READ, "pop with data must wait for queue read")
  `ASSERT_NEXT(a_read_one_cycle, clk_i, rst_ni, state_q == ST_READ, state_q == ST_OUT, "queue read wait must last one cycle")

endmodule

`default_nettype wire

/* hdl/viq_dp.sv */
// Datapath: acknowledge latches, adapt flags, ring pointers, pending store, result.
`timescale 1ns / 1ps
`default_nettype none

module viq_dp import viq_pkg::*; #(
  parameter int unsigned QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  input  wire logic [ACTION_W-1:0]   action_i,
  input  wire logic                  current_vm_i,
  input  wire logic                  target_vm_i,
  input  wire logic [ID_W-1:0]       irq_id_i,
  output logic      [STATUS_W-1:0]   status_res_o,
  output logic      [ID_W-1:0]       value_o,
  output logic                       nonempty_o,
  output logic                       forward_valid_o,
  output logic      [ID_W-1:0]       forward_id_o
);

  localparam int unsigned IDX_W     = $clog2(QUEUE_SLOTS);
  localparam int unsigned ADDR_W    = IDX_W + GUEST_W;
  localparam int unsigned RAM_DEPTH = GUEST_COUNT << IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  logic [ID_W-1:0]  ack_q  [GUEST_COUNT];
  logic [ID_W-1:0]  ack_d  [GUEST_COUNT];
  logic             adapt_q[GUEST_COUNT];
  logic             adapt_d[GUEST_COUNT];
  logic [IDX_W-1:0] head_q [GUEST_COUNT];
  logic [IDX_W-1:0] head_d [GUEST_COUNT];
  logic [IDX_W-1:0] tail_q [GUEST_COUNT];
  logic [IDX_W-1:0] tail_d [GUEST_COUNT];

  logic [STATUS_W-1:0] stat_q, stat_d;
  logic [ID_W-1:0]     value_q, value_d;
  logic                ne_q, ne_d;
  logic                fwd_v_q, fwd_v_d;
  logic [ID_W-1:0]     fwd_id_q, fwd_id_d;

  action_e          act;
  logic             other_vm;
  logic             push_g;
  logic             pop_g;
  logic             is_push;
  logic             is_pop;
  logic             push_full;
  logic             pop_empty;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ID_W-1:0]  ram_rdata;

  assign act       = action_e'(action_i);
  assign other_vm  = ~current_vm_i;
  assign push_g    = (act == ACT_PUSH_OTHER) ? other_vm : current_vm_i;
  assign pop_g     = (act == ACT_POP_ADAPT) ? current_vm_i : target_vm_i;
  assign is_push   = (act == ACT_PUSH_OWN) || (act == ACT_PUSH_OTHER);
  assign is_pop    = (act == ACT_POP_ADAPT) || (act == ACT_POP);
  assign push_full = (next_idx(tail_q[push_g]) == head_q[push_g]);
  assign pop_empty = (head_q[pop_g] == tail_q[pop_g]);

  assign status_o.pop_read = is_pop && !pop_empty;

  assign ram_we    = cmd_i.accept && is_push && !push_full;
  assign ram_waddr = {push_g, tail_q[push_g]};
  // Read runs every cycle; the data is used only the cycle after a pop transfer.
  assign ram_raddr = {pop_g, head_q[pop_g]};

  viq_ram #(
    .WIDTH(ID_W),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(irq_id_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    ack_d    = ack_q;
    adapt_d  = adapt_q;
    head_d   = head_q;
    tail_d   = tail_q;
    stat_d   = stat_q;
    value_d  = value_q;
    ne_d     = ne_q;
    fwd_v_d  = fwd_v_q;
    fwd_id_d = fwd_id_q;
    if (cmd_i.accept) begin
      stat_d   = STAT_OK;
      value_d  = SPURIOUS_ID;
      ne_d     = 1'b0;
      fwd_v_d  = 1'b0;
      fwd_id_d = '0;
      unique case (act) inside
        ACT_EOI_FWD: begin
          fwd_v_d  = 1'b1;
          fwd_id_d = irq_id_i;
        end
        ACT_INJECT_CUR: begin
          if (adapt_q[current_vm_i]) begin
            adapt_d[current_vm_i] = 1'b0;
            stat_d                = STAT_SWALLOWED;
          end else begin
            ack_d[current_vm_i] = irq_id_i;
          end
        end
        ACT_READ_LATCH: value_d = ack_q[current_vm_i];
        ACT_PUSH_OWN, ACT_PUSH_OTHER: begin
          if (push_full) begin
            stat_d = STAT_FULL;
          end else begin
            tail_d[push_g] = next_idx(tail_q[push_g]);
          end
        end
        ACT_POP_ADAPT, ACT_POP: begin
          if (act == ACT_POP_ADAPT) begin
            adapt_d[current_vm_i] = 1'b1;
          end
          if (pop_empty) begin
            stat_d = STAT_EMPTY;
          end else begin
            head_d[pop_g] = next_idx(head_q[pop_g]);
          end
        end
        ACT_QUERY: ne_d = (head_q[target_vm_i] != tail_q[target_vm_i]);
        ACT_INJECT_OTHER: ack_d[other_vm] = irq_id_i;
        ACT_GUEST_EOI: begin
          ack_d[current_vm_i] = SPURIOUS_ID;
          fwd_v_d             = 1'b1;
          fwd_id_d            = irq_id_i;
        end
        default: ;
      endcase
    end
    if (cmd_i.load_rd) begin
      value_d = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GUEST_COUNT; g++) begin
        ack_q[g]   <= SPURIOUS_ID;
        adapt_q[g] <= 1'b0;
        head_q[g]  <= '0;
        tail_q[g]  <= '0;
      end
    end else begin
      ack_q   <= ack_d;
      adapt_q <= adapt_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q   <= stat_d;
    value_q  <= value_d;
    ne_q     <= ne_d;
    fwd_v_q  <= fwd_v_d;
    fwd_id_q <= fwd_id_d;
  end

  assign status_res_o    = stat_q;
  assign value_o         = value_q;
  assign nonempty_o      = ne_q;
  assign forward_valid_o = fwd_v_q;
  assign forward_id_o    = fwd_id_q;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_push_nonempty, clk_i, rst_ni, ram_we,
               head_q[$past(push_g)] != tail_q[$past(push_g)],
               "queue empty after a successful push")
  `ASSERT_NEXT(a_adapt_armed, clk_i, rst_ni, cmd_i.accept && (act == ACT_POP_ADAPT),
               adapt_q[$past(current_vm_i)], "adapt flag not set by pop for adapt")

endmodule

`default_nettype wire

/* hdl/virtual_irq_ack_latch_and_pending_fifo.sv */
// Top level: virtual IRQ acknowledge latches and per-guest pending ID queues.
//
//   channel  handshake                  payload
//   input    in_valid_i / in_stall_o    action_i, current_vm_i, target_vm_i, irq_id_i
//   output   out_valid_o / out_stall_i  status_o, value_o, nonempty_o,
//                                       forward_valid_o, forward_id_o
//
// One item at a time: transfer cycle, then the result is held in the output register.
// A pop from a non-empty queue first passes through the read state for the registered read
// of the pending store before the result is held, plus any output stall.
// Input is stalled until the result has been transferred.
// Reset sets the latches to 1023 and clears adapt flags and ring pointers; the pending
// store is not cleared, as only read data from occupied slots is ever used.
`timescale 1ns / 1ps
`default_nettype none

module virtual_irq_ack_latch_and_pending_fifo import viq_pkg::*; #(
  parameter int unsigned QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic                current_vm_i,
  input  wire logic                target_vm_i,
  input  wire logic [ID_W-1:0]     irq_id_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [ID_W-1:0]     value_o,
  output logic                     nonempty_o,
  output logic                     forward_valid_o,
  output logic      [ID_W-1:0]     forward_id_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  viq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  viq_dp #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .action_i       (action_i),
    .current_vm_i   (current_vm_i),
    .target_vm_i    (target_vm_i),
    .irq_id_i       (irq_id_i),
    .status_res_o   (status_o),
    .value_o        (value_o),
    .nonempty_o     (nonempty_o),
    .forward_valid_o(forward_valid_o),
    .forward_id_o   (forward_id_o)
  );

endmodule

`default_nettype wire

/* verif/virtual_irq_ack_latch_and_pending_fifo_tb.sv */
// Testbench for the virtual IRQ acknowledge latch and per-guest pending ID queues.
`timescale 1ns / 1ps

module virtual_irq_ack_latch_and_pending_fifo_tb import viq_pkg::*; ();

  localparam int unsigned SLOTS          = QUEUE_SLOTS_DEF;
  localparam int unsigned RANDOM_CMDS    = 1450;
  localparam int unsigned HOLD_AT        = 120;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned MAX_PRINTED    = 100;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic                cur;
    logic                tgt;
    logic [ID_W-1:0]     id;
    bit                  wait_drain;  // hold this one back until all results are in
  } irq_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     value;
    logic                nonempty;
    logic                fwd_valid;
    logic [ID_W-1:0]     fwd_id;
  } irq_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [ACTION_W-1:0] action_i     = '0;
  logic                current_vm_i = 1'b0;
  logic                target_vm_i  = 1'b0;
  logic [ID_W-1:0]     irq_id_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     value_o;
  logic                nonempty_o;
  logic                forward_valid_o;
  logic [ID_W-1:0]     forward_id_o;

  virtual_irq_ack_latch_and_pending_fifo #(
    .QUEUE_SLOTS(SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .current_vm_i   (current_vm_i),
    .target_vm_i    (target_vm_i),
    .irq_id_i       (irq_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .value_o        (value_o),
    .nonempty_o     (nonempty_o),
    .forward_valid_o(forward_valid_o),
    .forward_id_o   (forward_id_o)
  );

  always #5 clk_i = ~clk_i;

  irq_cmd_t    pending_cmds[$];
  irq_result_t expected_results[$];
  int unsigned n_accepted  = 0;
  int unsigned n_errors    = 0;
  int unsigned total_cmds  = 0;
  int unsigned phase_len   = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  bit          in_took     = 1'b0;

  // Predicted state of both guests
  logic [ID_W-1:0] ack_model  [GUEST_COUNT];
  bit              adapt_armed[GUEST_COUNT];
  logic [ID_W-1:0] pend_model [GUEST_COUNT][SLOTS];
  int unsigned     rd_ptr     [GUEST_COUNT];
  int unsigned     wr_ptr     [GUEST_COUNT];

  task automatic report_error(input string msg);
    if (n_errors < MAX_PRINTED)
      $display("%0t ns: mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // Ring keeps one slot free, so full is next(tail) == head
  function automatic logic [STATUS_W-1:0] pend_push(input int g, input logic [ID_W-1:0] id);
    int unsigned nxt;
    nxt = (wr_ptr[g] + 1) % SLOTS;
    if (nxt == rd_ptr[g])
      return STAT_FULL;
    pend_model[g][wr_ptr[g]] = id;
    wr_ptr[g] = nxt;
    return STAT_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] pend_pop(input int g, output logic [ID_W-1:0] id);
    if (rd_ptr[g] == wr_ptr[g]) begin
      id = SPURIOUS_ID;
      return STAT_EMPTY;
    end
    id = pend_model[g][rd_ptr[g]];
    rd_ptr[g] = (rd_ptr[g] + 1) % SLOTS;
    return STAT_OK;
  endfunction

  function automatic irq_result_t apply_command(input irq_cmd_t c);
    irq_result_t r;
    int          cur;
    int          other;
    int          tgt;
    cur         = c.cur;
    other       = !c.cur;
    tgt         = c.tgt;
    r.status    = STAT_OK;
    r.value     = SPURIOUS_ID;
    r.nonempty  = 1'b0;
    r.fwd_valid = 1'b0;
    r.fwd_id    = '0;
    case (c.action)
      ACT_EOI_FWD: begin
        r.fwd_valid = 1'b1;
        r.fwd_id    = c.id;
      end
      ACT_INJECT_CUR: begin
        if (adapt_armed[cur]) begin
          adapt_armed[cur] = 1'b0;
          r.status         = STAT_SWALLOWED;
        end else begin
          ack_model[cur] = c.id;
        end
      end
      ACT_READ_LATCH:   r.value = ack_model[cur];
      ACT_PUSH_OWN:     r.status = pend_push(cur, c.id);
      ACT_POP_ADAPT: begin
        // flag is armed even when the queue turns out empty
        adapt_armed[cur] = 1'b1;
        r.status         = pend_pop(cur, r.value);
      end
      ACT_QUERY:        r.nonempty = (rd_ptr[tgt] != wr_ptr[tgt]);
      ACT_PUSH_OTHER:   r.status = pend_push(other, c.id);
      ACT_POP:          r.status = pend_pop(tgt, r.value);
      ACT_INJECT_OTHER: ack_model[other] = c.id;
      ACT_GUEST_EOI: begin
        ack_model[cur] = SPURIOUS_ID;
        r.fwd_valid    = 1'b1;
        r.fwd_id       = c.id;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(7))
      0:       return '0;
      1:       return SPURIOUS_ID;
      default: return ID_W'($urandom);
    endcase
  endfunction

  task automatic add_cmd(input logic [ACTION_W-1:0] a, input logic cur, input logic tgt,
                         input logic [ID_W-1:0] id, input bit wait_drain);
    irq_cmd_t c;
    c.action     = a;
    c.cur        = cur;
    c.tgt        = tgt;
    c.id         = id;
    c.wait_drain = wait_drain;
    pending_cmds.push_back(c);
  endtask

  // Enough pushes to overflow the queue of guest g from any level
  task automatic add_fill(input logic g);
    int unsigned n;
    n = $urandom_range(72, 64);
    repeat (n) begin
      if ($urandom_range(1))
        add_cmd(ACT_PUSH_OWN, g, 1'($urandom_range(1)), pick_id(), 1'b0);
      else
        add_cmd(ACT_PUSH_OTHER, !g, 1'($urandom_range(1)), pick_id(), 1'b0);
    end
  endtask

  task automatic add_drain(input logic g);
    int unsigned n;
    n = $urandom_range(72, 64);
    repeat (n) begin
      case ($urandom_range(5))
        0:       add_cmd(ACT_POP_ADAPT, g, 1'($urandom_range(1)), pick_id(), 1'b0);
        1:       add_cmd(ACT_QUERY, 1'($urandom_range(1)), g, pick_id(), 1'b0);
        default: add_cmd(ACT_POP, 1'($urandom_range(1)), g, pick_id(), 1'b0);
      endcase
    end
  endtask

  function automatic int unsigned send_idle_pct();
    if (n_accepted < phase_len)
      return 25;
    if (n_accepted < 2 * phase_len)
      return 86;
    return 0;
  endfunction

  function automatic int unsigned recv_stall_pct();
    if (n_accepted < phase_len)
      return 86;
    if (n_accepted < 2 * phase_len)
      return 25;
    return 0;
  endfunction

  initial begin
    int unsigned n_directed;
    logic        g;
    int unsigned n;

    for (int i = 0; i < GUEST_COUNT; i++) begin
      ack_model[i]   = SPURIOUS_ID;
      adapt_armed[i] = 1'b0;
      rd_ptr[i]      = 0;
      wr_ptr[i]      = 0;
    end

    // Directed: reset latch, empty pops, adapt swallowing, cross-guest traffic, unused codes
    add_cmd(ACT_READ_LATCH,   1'b0, 1'b0, 10'd0,      1'b0);
    add_cmd(ACT_POP,          1'b0, 1'b0, 10'd0,      1'b0);
    add_cmd(ACT_QUERY,        1'b0, 1'b1, 10'd0,      1'b0);
    add_cmd(ACT_INJECT_CUR,   1'b0, 1'b0, 10'd0,      1'b0);
    add_cmd(ACT_READ_LATCH,   1'b0, 1'b1, 10'd0,      1'b0);
    add_cmd(ACT_INJECT_CUR,   1'b0, 1'b0, SPURIOUS_ID, 1'b0);
    add_cmd(ACT_READ_LATCH,   1'b0, 1'b0, 10'd0,      1'b0);
    add_cmd(ACT_PUSH_OWN,     1'b1, 1'b0, 10'd0,      1'b0);
    add_cmd(ACT_PUSH_OTHER,   1'b0, 1'b1, SPURIOUS_ID, 1'b0);
    add_cmd(ACT_QUERY,        1'b0, 1'b1, 10'd0,      1'b0);
    add_cmd(ACT_POP_ADAPT,    1'b1, 1'b0, 10'd0,      1'b0);
    add_cmd(ACT_INJECT_OTHER, 1'b0, 1'b1, 10'd512,    1'b0);
    add_cmd(ACT_INJECT_CUR,   1'b1, 1'b0, 10'd7,      1'b0);
    add_cmd(ACT_READ_LATCH,   1'b1, 1'b0, 10'd0,      1'b0);
    add_cmd(ACT_POP,          1'b0, 1'b1, 10'd0,      1'b0);
    add_cmd(ACT_POP_ADAPT,    1'b0, 1'b1, 10'd0,      1'b0);
    add_cmd(ACT_INJECT_CUR,   1'b0, 1'b0, 10'd341,    1'b0);
    add_cmd(ACT_GUEST_EOI,    1'b1, 1'b1, 10'd512,    1'b0);
    add_cmd(ACT_READ_LATCH,   1'b1, 1'b1, 10'd0,      1'b0);
    add_cmd(ACT_EOI_FWD,      1'b1, 1'b0, SPURIOUS_ID, 1'b0);
    for (int a = 10; a < 16; a++)
      add_cmd(ACTION_W'(a), a[0], a[1], pick_id(), 1'b0);
    n_directed = pending_cmds.size();

    // Start the random part from an idle block, then fill guest 0 to overflow and drain it
    add_cmd(ACT_QUERY, 1'b0, 1'b0, 10'd0, 1'b1);
    add_fill(1'b0);
    add_drain(1'b0);

    while (pending_cmds.size() < n_directed + RANDOM_CMDS) begin
      g = 1'($urandom_range(1));
      if ($urandom_range(24) == 0)
        add_cmd(ACT_QUERY, 1'($urandom_range(1)), g, pick_id(), 1'b1);
      n = $urandom_range(99);
      if (n < 7) begin
        add_fill(g);
      end else if (n < 14) begin
        add_drain(g);
      end else if (n < 45) begin
        repeat ($urandom_range(12, 2)) begin
          case ($urandom_range(5))
            0: add_cmd(ACT_PUSH_OWN,   g,  1'($urandom_range(1)), pick_id(), 1'b0);
            1: add_cmd(ACT_PUSH_OTHER, !g, 1'($urandom_range(1)), pick_id(), 1'b0);
            2: add_cmd(ACT_POP,        1'($urandom_range(1)), g,  pick_id(), 1'b0);
            3: add_cmd(ACT_POP_ADAPT,  g,  1'($urandom_range(1)), pick_id(), 1'b0);
            4: add_cmd(ACT_QUERY,      1'($urandom_range(1)), g,  pick_id(), 1'b0);
            default: add_cmd(ACT_PUSH_OWN, g, 1'($urandom_range(1)), pick_id(), 1'b0);
          endcase
        end
      end else if (n < 75) begin
        // acknowledge life cycle of one guest, optionally with the adapt flag armed
        if ($urandom_range(1))
          add_cmd(ACT_POP_ADAPT, g, 1'($urandom_range(1)), pick_id(), 1'b0);
        add_cmd(ACT_INJECT_CUR, g, 1'($urandom_range(1)), pick_id(), 1'b0);
        if ($urandom_range(1))
          add_cmd(ACT_INJECT_CUR, g, 1'($urandom_range(1)), pick_id(), 1'b0);
        add_cmd(ACT_READ_LATCH, g, 1'($urandom_range(1)), pick_id(), 1'b0);
        if ($urandom_range(2) == 0) begin
          add_cmd(ACT_INJECT_OTHER, !g, 1'($urandom_range(1)), pick_id(), 1'b0);
          add_cmd(ACT_READ_LATCH, g, 1'($urandom_range(1)), pick_id(), 1'b0);
        end
        add_cmd(ACT_GUEST_EOI, g, 1'($urandom_range(1)), pick_id(), 1'b0);
        add_cmd(ACT_READ_LATCH, g, 1'($urandom_range(1)), pick_id(), 1'b0);
        if ($urandom_range(1))
          add_cmd(ACT_EOI_FWD, g, 1'($urandom_range(1)), pick_id(), 1'b0);
      end else begin
        repeat ($urandom_range(6, 1))
          add_cmd(ACTION_W'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), pick_id(), 1'b0);
      end
    end

    total_cmds = pending_cmds.size();
    phase_len  = total_cmds / 3;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (n_accepted == total_cmds);
    wait (expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0)
      $display("[virtual_irq_ack_latch_and_pending_fifo] OK");
    else
      $display("[virtual_irq_ack_latch_and_pending_fifo] ERROR");
    $finish;
  end

  // Command driver: a new command is only picked once the last one went across
  always @(negedge clk_i) begin
    irq_cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_took)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct() &&
          (!pending_cmds[0].wait_drain || expected_results.size() == 0)) begin
        c = pending_cmds.pop_front();
        action_i     <= c.action;
        current_vm_i <= c.cur;
        target_vm_i  <= c.tgt;
        irq_id_i     <= c.id;
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver stall, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    irq_cmd_t    c;
    irq_result_t want;
    bit          in_fire;
    bit          out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    in_took <= in_fire;
    if (in_fire) begin
      c.action     = action_i;
      c.cur        = current_vm_i;
      c.tgt        = target_vm_i;
      c.id         = irq_id_i;
      c.wait_drain = 1'b0;
      expected_results.push_back(apply_command(c));
      n_accepted++;
    end
    if (out_fire) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("result with nothing outstanding, value %0d", value_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_error($sformatf("status got %0d want %0d", status_o, want.status));
        if (value_o !== want.value)
          report_error($sformatf("value got %0d want %0d", value_o, want.value));
        if (nonempty_o !== want.nonempty)
          report_error($sformatf("nonempty got %0d want %0d", nonempty_o, want.nonempty));
        if (forward_valid_o !== want.fwd_valid)
          report_error($sformatf("forward_valid got %0d want %0d",
                                 forward_valid_o, want.fwd_valid));
        if (forward_id_o !== want.fwd_id)
          report_error($sformatf("forward_id got %0d want %0d", forward_id_o, want.fwd_id));
      end
    end
    idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[virtual_irq_ack_latch_and_pending_fifo] ERROR");
      $finish;
    end
  end

endmodule
